/* src/dcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dcs_pkg;

  // phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MIX  = 2'd1;
  localparam logic [1:0] PH_PUMP = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TDS_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_DAYS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOUR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_MINUTES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_TIMEOUT_SEC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_ON_MS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFF_MS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STORED_LAST_FED = 3'd7;

  localparam int SEC_PER_DAY = 86400;
  localparam int SEC_PER_MIN = 60;

  localparam int DAY_SPAN_W  = 26;  // 511 days in seconds
  localparam int PUMP_SPAN_W = 17;  // 2047 minutes in seconds

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 40;

  // reset values
  localparam logic [15:0] RST_TDS_THRESHOLD   = 16'd800;
  localparam logic [8:0]  RST_INTERVAL_DAYS   = 9'd7;
  localparam logic [4:0]  RST_START_HOUR      = 5'd7;
  localparam logic [10:0] RST_PUMP_MINUTES    = 11'd5;
  localparam logic [15:0] RST_MIX_TIMEOUT_SEC = 16'd300;
  localparam logic [15:0] RST_PULSE_ON_MS     = 16'd500;
  localparam logic [15:0] RST_PULSE_OFF_MS    = 16'd1000;

  typedef struct packed {
    logic [15:0]            tds_threshold;
    logic [DAY_SPAN_W-1:0]  day_span;       // interval_days * 86400
    logic [4:0]             start_hour;
    logic [PUMP_SPAN_W-1:0] pump_span;      // pump_minutes * 60
    logic [15:0]            mix_timeout_sec;
    logic [15:0]            pulse_on_ms;
    logic [15:0]            pulse_off_ms;
    logic [31:0]            stored_last_fed;
  } cfg_t;

  typedef struct packed {
    logic        force_start;
    logic [15:0] tds_ppm;
    logic [5:0]  minute_now;
    logic [4:0]  hour_now;
    logic [31:0] now_ms;
    logic [31:0] now_sec;
  } in_item_t;

  typedef struct packed {
    logic [31:0] last_fed_time;
    logic        save_strobe;
    logic [1:0]  phase;
    logic        pump_on;
    logic        motor_on;
  } out_item_t;

endpackage

`default_nettype wire

/* src/dcs_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module dcs_cfg_regs
  import dcs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [31:0]          wr_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  // spans in seconds are formed at write time, so the tick path only compares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tds_threshold   <= RST_TDS_THRESHOLD;
      cfg_r.day_span        <= DAY_SPAN_W'(RST_INTERVAL_DAYS) * DAY_SPAN_W'(SEC_PER_DAY);
      cfg_r.start_hour      <= RST_START_HOUR;
      cfg_r.pump_span       <= PUMP_SPAN_W'(RST_PUMP_MINUTES) * PUMP_SPAN_W'(SEC_PER_MIN);
      cfg_r.mix_timeout_sec <= RST_MIX_TIMEOUT_SEC;
      cfg_r.pulse_on_ms     <= RST_PULSE_ON_MS;
      cfg_r.pulse_off_ms    <= RST_PULSE_OFF_MS;
      cfg_r.stored_last_fed <= 32'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TDS_THRESHOLD:   cfg_r.tds_threshold <= wr_data[15:0];
        REG_INTERVAL_DAYS:
          cfg_r.day_span <= DAY_SPAN_W'(wr_data[8:0]) * DAY_SPAN_W'(SEC_PER_DAY);
        REG_START_HOUR:      cfg_r.start_hour <= wr_data[4:0];
        REG_PUMP_MINUTES:
          cfg_r.pump_span <= PUMP_SPAN_W'(wr_data[10:0]) * PUMP_SPAN_W'(SEC_PER_MIN);
        REG_MIX_TIMEOUT_SEC: cfg_r.mix_timeout_sec <= wr_data[15:0];
        REG_PULSE_ON_MS:     cfg_r.pulse_on_ms <= wr_data[15:0];
        REG_PULSE_OFF_MS:    cfg_r.pulse_off_ms <= wr_data[15:0];
        REG_STORED_LAST_FED: cfg_r.stored_last_fed <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/dcs_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module dcs_step
  import dcs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] mix_start_r, mix_start_nxt;
  logic [31:0] pump_start_r, pump_start_nxt;
  logic [31:0] pulse_mark_r, pulse_mark_nxt;
  logic        pump_r, pump_nxt;
  logic        motor_r, motor_nxt;
  logic        manual_r, manual_nxt;
  logic [31:0] last_fed_r, last_fed_nxt;
  logic        fed_valid_r;
  logic        save;

  logic [31:0]        fed_base;
  logic [31:0]        age;
  logic signed [32:0] age_s;
  logic signed [32:0] neg_day;
  logic               days_ok;
  logic               start_due;
  logic [31:0]        mix_age;
  logic [31:0]        pump_age;
  logic [31:0]        pulse_age;
  logic [15:0]        pulse_span;

  // first tick after reset picks up the saved time, or the clock if unknown
  always_comb begin
    if (fed_valid_r) fed_base = last_fed_r;
    else if (cfg.stored_last_fed != 32'd0) fed_base = cfg.stored_last_fed;
    else fed_base = item.now_sec;
  end

  // whole days truncate toward zero: zero days covers (-86400, 86400)
  assign age     = item.now_sec - fed_base;
  assign age_s   = {age[31], age};
  assign neg_day = -$signed(33'(SEC_PER_DAY));
  assign days_ok = (cfg.day_span == '0) ? (age_s > neg_day)
                                        : (age_s >= $signed(33'(cfg.day_span)));
  assign start_due = days_ok && (item.hour_now == cfg.start_hour)
                   && (item.minute_now == 6'd0);

  assign mix_age    = item.now_sec - mix_start_r;
  assign pump_age   = item.now_sec - pump_start_r;
  assign pulse_age  = item.now_ms - pulse_mark_r;
  assign pulse_span = pump_r ? cfg.pulse_on_ms : cfg.pulse_off_ms;

  always_comb begin
    phase_nxt      = phase_r;
    mix_start_nxt  = mix_start_r;
    pump_start_nxt = pump_start_r;
    pulse_mark_nxt = pulse_mark_r;
    pump_nxt       = pump_r;
    motor_nxt      = motor_r;
    manual_nxt     = manual_r;
    last_fed_nxt   = fed_base;
    save           = 1'b0;
    if (item.force_start) begin
      // manual start touches nothing but the run flag, the phase and the mix timer
      manual_nxt    = 1'b1;
      phase_nxt     = PH_MIX;
      mix_start_nxt = item.now_sec;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          motor_nxt = 1'b0;
          pump_nxt  = 1'b0;
          if (start_due) begin
            mix_start_nxt = item.now_sec;
            phase_nxt     = PH_MIX;
          end
        end
        PH_MIX: begin
          if (item.tds_ppm < cfg.tds_threshold) begin
            motor_nxt = 1'b1;
            if (mix_age > 32'(cfg.mix_timeout_sec)) begin
              motor_nxt = 1'b0;
              phase_nxt = PH_DONE;
            end
          end else begin
            motor_nxt      = 1'b0;
            pump_start_nxt = item.now_sec;
            pulse_mark_nxt = item.now_ms;
            pump_nxt       = 1'b0;
            phase_nxt      = PH_PUMP;
          end
        end
        PH_PUMP: begin
          if (pump_age >= 32'(cfg.pump_span)) begin
            pump_nxt  = 1'b0;
            phase_nxt = PH_DONE;
          end else if (pulse_age >= 32'(pulse_span)) begin
            pulse_mark_nxt = item.now_ms;
            pump_nxt       = !pump_r;
          end
        end
        PH_DONE: begin
          if (!manual_r) begin
            last_fed_nxt = item.now_sec;
            save         = 1'b1;
          end
          manual_nxt = 1'b0;
          phase_nxt  = PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      mix_start_r  <= 32'd0;
      pump_start_r <= 32'd0;
      pulse_mark_r <= 32'd0;
      pump_r       <= 1'b0;
      motor_r      <= 1'b0;
      manual_r     <= 1'b0;
      last_fed_r   <= 32'd0;
      fed_valid_r  <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      mix_start_r  <= mix_start_nxt;
      pump_start_r <= pump_start_nxt;
      pulse_mark_r <= pulse_mark_nxt;
      pump_r       <= pump_nxt;
      motor_r      <= motor_nxt;
      manual_r     <= manual_nxt;
      last_fed_r   <= last_fed_nxt;
      fed_valid_r  <= 1'b1;
    end
  end

  assign result.motor_on      = motor_nxt;
  assign result.pump_on       = pump_nxt;
  assign result.phase         = phase_nxt;
  assign result.save_strobe   = save;
  assign result.last_fed_time = last_fed_nxt;

endmodule

`default_nettype wire

/* src/dosing_cycle_sequencer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake          | Payload
// in_     | slave     | in_tvalid/tready   | tick: tdata 96 bits, tuser force_start
// out_    | master    | out_tvalid/tready  | drive levels, phase, save, last fed time
// cfg_    | slave     | cfg_valid/cfg_ready| register index 3 bits, data 32 bits
//
// Each request passes an input register, then next-state logic that writes
// the state and the output register, one request per cycle sustained while
// out_ is not stalled. The output register frees the input side, so
// a new request is taken while a result waits; only a stalled out_ side with
// both registers full drops in_tready. cfg_ready is always high.
// Synchronous active-low reset: phase idle, timers zero, last fed time
// reloaded on the first request after reset.

module dosing_cycle_sequencer_unit
  import dcs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: now_sec[31:0], now_ms[63:32], hour_now[68:64],
  //           minute_now[74:69], tds_ppm[90:75], zero [95:91]
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: force_start[0]
  input  wire logic [0:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_tdata: motor_on[0], pump_on[1], phase[3:2], save_strobe[4],
  //            last_fed_time[36:5], zero [39:37]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]           cfg_data
);

  cfg_t      cfg;
  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t step_out;
  out_item_t out_r;
  logic      out_valid_r;
  logic      out_free;
  logic      step_en;

  assign cfg_ready = 1'b1;

  dcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // output register can load when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r.now_sec     <= in_tdata[31:0];
      in_r.now_ms      <= in_tdata[63:32];
      in_r.hour_now    <= in_tdata[68:64];
      in_r.minute_now  <= in_tdata[74:69];
      in_r.tds_ppm     <= in_tdata[90:75];
      in_r.force_start <= in_tuser[0];
    end
  end

  dcs_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_r),
    .cfg     (cfg),
    .result  (step_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= step_out;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.last_fed_time, out_r.save_strobe, out_r.phase,
                       out_r.pump_on, out_r.motor_on};

  // a feeding is only recorded on the step that returns to idle
  a_save_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.save_strobe |-> out_r.phase == PH_IDLE)
    else $error("save strobe outside idle");

  // the stirrer only runs while mixing
  a_motor_in_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.motor_on |-> out_r.phase == PH_MIX)
    else $error("motor on outside mixing");

  // input side only stalls when both registers are full and output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without backpressure");

  // a stepped request always leaves a result behind
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("step did not produce a result");

endmodule

`default_nettype wire
